// File: design/i2c_bus_address_scanner_unit_macros.svh
// ----------------------------------------------------------------------------
// I2C bus scanner assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_BUS_ADDRESS_SCANNER_UNIT_MACROS_SVH
`define I2C_BUS_ADDRESS_SCANNER_UNIT_MACROS_SVH

// same-cycle implication
`define I2CSCAN_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("i2cscan assertion failed");

// next-cycle implication
`define I2CSCAN_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("i2cscan assertion failed");

`endif

// File: design/i2cscan_pkg.sv
// ----------------------------------------------------------------------------
// I2C bus scanner package
// Phase codes, constants and shared structs of the scanner.
// ----------------------------------------------------------------------------
package i2cscan_pkg;

    localparam int unsigned AddrW   = 7;
    localparam int unsigned EndW    = 8;
    localparam int unsigned TicksW  = 16;
    localparam int unsigned BitIdxW = 3;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [AddrW-1:0]   ADDR_MAX  = 7'd127;
    localparam logic [EndW-1:0]    END_LIMIT = 8'd128;
    localparam logic [BitIdxW-1:0] LAST_BIT  = 3'd7;

    localparam logic [CfgIdxW-1:0] REG_SCAN_FIRST = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SCAN_END   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_GAP_TICKS  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS = 3'd3;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_BIT_LOW,
        PH_BIT_SET,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_REL,
        PH_ACK_HIGH,
        PH_ACK_SAMP,
        PH_HOLD,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C,
        PH_STOP_D,
        PH_GAP,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [AddrW-1:0]  scan_first;
        logic [EndW-1:0]   scan_end;
        logic [TicksW-1:0] gap_ticks;
        logic [TicksW-1:0] found_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic             scl_out;
        logic             sda_out;
        logic             found_valid;
        logic [AddrW-1:0] found_address;
        logic [AddrW-1:0] device_count;
        logic             scan_done;
        logic             none_found;
    } t_result;

endpackage

// File: design/i2cscan_core.sv
// ----------------------------------------------------------------------------
// I2C bus scanner phase engine
// Holds the bus phase and scan state; advances at most one phase per accepted
// beat and presents the result of that beat.
// ----------------------------------------------------------------------------
module i2cscan_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_go,
    input  logic                i_sda_in,
    input  i2cscan_pkg::t_cfg   i_cfg,
    output i2cscan_pkg::t_result o_res
);
    import i2cscan_pkg::*;

    t_phase              r_phase, n_phase;
    logic [AddrW-1:0]    r_probe, n_probe;
    logic [BitIdxW-1:0]  r_bit_idx, n_bit_idx;
    logic [AddrW-1:0]    r_total, n_total;
    logic [TicksW-1:0]   r_wait, n_wait;
    logic                r_scl, n_scl;
    logic                r_sda, n_sda;
    logic                r_done, n_done;

    logic [EndW-1:0]     end_lim;
    logic [EndW-1:0]     probe_ext;
    logic [EndW-1:0]     probe_inc;
    logic [EndW-1:0]     first_ext;
    logic [EndW-1:0]     byte_val;
    logic                found;

    assign end_lim   = (i_cfg.scan_end > END_LIMIT) ? END_LIMIT : i_cfg.scan_end;
    assign probe_ext = {1'b0, r_probe};
    assign probe_inc = probe_ext + 8'd1;
    assign first_ext = {1'b0, i_cfg.scan_first};
    assign byte_val  = {r_probe, 1'b0};

    always_comb begin
        n_phase   = r_phase;
        n_probe   = r_probe;
        n_bit_idx = r_bit_idx;
        n_total   = r_total;
        n_wait    = r_wait;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_done    = r_done;
        found     = 1'b0;
        case (r_phase)
            PH_IDLE, PH_DONE: begin
                n_scl = 1'b1;
                n_sda = 1'b1;
                if (i_go) begin
                    n_total = '0;
                    n_probe = i_cfg.scan_first;
                    if (first_ext >= end_lim) begin
                        n_done  = 1'b1;
                        n_phase = PH_DONE;
                    end else begin
                        n_done  = 1'b0;
                        n_phase = PH_START_A;
                    end
                end
            end
            PH_START_A: begin
                n_scl   = 1'b1;
                n_sda   = 1'b1;
                n_phase = PH_START_B;
            end
            PH_START_B: begin
                n_sda     = 1'b0;
                n_bit_idx = '0;
                n_phase   = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
                n_scl   = 1'b0;
                n_phase = PH_BIT_SET;
            end
            PH_BIT_SET: begin
                n_sda   = byte_val[~r_bit_idx];
                n_phase = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
                n_scl = 1'b1;
                if (r_bit_idx == LAST_BIT) begin
                    n_bit_idx = '0;
                    n_phase   = PH_ACK_LOW;
                end else begin
                    n_bit_idx = r_bit_idx + 3'd1;
                    n_phase   = PH_BIT_LOW;
                end
            end
            PH_ACK_LOW: begin
                n_scl   = 1'b0;
                n_phase = PH_ACK_REL;
            end
            PH_ACK_REL: begin
                n_sda   = 1'b1;
                n_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                n_scl   = 1'b1;
                n_phase = PH_ACK_SAMP;
            end
            PH_ACK_SAMP: begin
                n_scl = 1'b0;
                if (!i_sda_in) begin
                    found   = 1'b1;
                    n_total = (r_total < ADDR_MAX) ? r_total + 7'd1 : r_total;
                    n_wait  = i_cfg.found_hold_ticks;
                    n_phase = PH_HOLD;
                end else begin
                    n_phase = PH_STOP_A;
                end
            end
            PH_HOLD: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 16'd1;
                end else begin
                    n_phase = PH_STOP_A;
                end
            end
            PH_STOP_A: begin
                n_scl   = 1'b0;
                n_phase = PH_STOP_B;
            end
            PH_STOP_B: begin
                n_sda   = 1'b0;
                n_phase = PH_STOP_C;
            end
            PH_STOP_C: begin
                n_scl   = 1'b1;
                n_phase = PH_STOP_D;
            end
            PH_STOP_D: begin
                n_sda   = 1'b1;
                n_wait  = i_cfg.gap_ticks;
                n_phase = PH_GAP;
            end
            PH_GAP: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 16'd1;
                end else if (r_probe == ADDR_MAX || probe_inc >= end_lim) begin
                    n_done  = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_probe = r_probe + 7'd1;
                    n_phase = PH_START_A;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_scl   = 1'b1;
                n_sda   = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_res.scl_out       = n_scl;
        o_res.sda_out       = n_sda;
        o_res.found_valid   = found;
        o_res.found_address = found ? r_probe : '0;
        o_res.device_count  = n_total;
        o_res.scan_done     = n_done;
        o_res.none_found    = n_done && (n_total == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_probe   <= '0;
            r_bit_idx <= '0;
            r_total   <= '0;
            r_wait    <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_done    <= 1'b0;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_probe   <= n_probe;
            r_bit_idx <= n_bit_idx;
            r_total   <= n_total;
            r_wait    <= n_wait;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_done    <= n_done;
        end
    end

endmodule

// File: design/i2c_bus_address_scanner_unit.sv
// ----------------------------------------------------------------------------
// I2C bus address scanner
// Tick-driven I2C master that probes a range of 7-bit addresses for an ACK.
// Each input beat is one bus tick and yields exactly one result beat, which
// appears in the output register on the clock after the input is taken. The
// block takes one beat per clock: the phase register moves at most one phase
// per beat, and the output register frees itself in the same cycle that its
// beat is taken, so the input stalls only while a result waits behind a
// stalled output. Hold and gap delays are counted in beats, not clocks.
// Configuration writes are applied on the clock edge where i_cfg_we is high.
// ----------------------------------------------------------------------------
module i2c_bus_address_scanner_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [i2cscan_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [i2cscan_pkg::TicksW-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_go,
    input  logic                                 i_sda_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_scl_out,
    output logic                                 o_sda_out,
    output logic                                 o_found_valid,
    output logic [i2cscan_pkg::AddrW-1:0]        o_found_address,
    output logic [i2cscan_pkg::AddrW-1:0]        o_device_count,
    output logic                                 o_scan_done,
    output logic                                 o_none_found
);
    import i2cscan_pkg::*;

    t_cfg    r_cfg;
    t_result core_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_take;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scan_first       <= 7'd0;
            r_cfg.scan_end         <= 8'd127;
            r_cfg.gap_ticks        <= 16'd100;
            r_cfg.found_hold_ticks <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCAN_FIRST: r_cfg.scan_first       <= i_cfg_data[AddrW-1:0];
                REG_SCAN_END:   r_cfg.scan_end         <= i_cfg_data[EndW-1:0];
                REG_GAP_TICKS:  r_cfg.gap_ticks        <= i_cfg_data;
                REG_HOLD_TICKS: r_cfg.found_hold_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i2cscan_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (in_take),
        .i_go     (i_go),
        .i_sda_in (i_sda_in),
        .i_cfg    (r_cfg),
        .o_res    (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scl_out       = r_res.scl_out;
    assign o_sda_out       = r_res.sda_out;
    assign o_found_valid   = r_res.found_valid;
    assign o_found_address = r_res.found_address;
    assign o_device_count  = r_res.device_count;
    assign o_scan_done     = r_res.scan_done;
    assign o_none_found    = r_res.none_found;

`include "i2c_bus_address_scanner_unit_macros.svh"

    `I2CSCAN_ASSERT_NEXT(a_beat_gives_result, in_take, o_out_valid)
    `I2CSCAN_ASSERT_NOW(a_found_counted, o_out_valid && o_found_valid, o_device_count != '0)
    `I2CSCAN_ASSERT_NOW(a_none_only_when_done, o_out_valid && o_none_found,
        o_scan_done && o_device_count == '0)

endmodule

// File: verif/tb_i2c_bus_address_scanner_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C bus address scanner testbench
// Drives tick beats (go, sampled SDA) into the scanner and checks every result
// beat against a cycle-free scanner model kept in the bench, or a directed
// row's typed result. A short directed table covers idle, empty range, spare
// register indexes and an end bound above 128. Random phases follow, each of
// which may reprogram the range and the delays between beats. A closing run
// loads the largest hold and gap counts. Both handshakes idle in random
// bursts, and one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb_i2c_bus_address_scanner_unit;
    import i2cscan_pkg::*;

    localparam int RAND_PHASES    = 12;
    localparam int BACKLOG_PHASE  = 4;
    localparam int BACKLOG_CYCLES = 64;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DIR_ROWS       = 23;

    localparam logic [CfgIdxW-1:0] REG_SPARE_4 = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPARE_7 = 3'd7;

    localparam t_result BUS_IDLE   = '{1'b1, 1'b1, 1'b0, 7'd0, 7'd0, 1'b0, 1'b0};
    localparam t_result DONE_EMPTY = '{1'b1, 1'b1, 1'b0, 7'd0, 7'd0, 1'b1, 1'b1};

    typedef struct packed {
        logic               wr;
        logic [CfgIdxW-1:0] idx;
        logic [TicksW-1:0]  data;
        logic               go;
        logic               sda;
        logic               typed;
        t_result            want;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [TicksW-1:0]  i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               i_go        = 1'b0;
    logic               i_sda_in    = 1'b1;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_scl_out;
    logic               o_sda_out;
    logic               o_found_valid;
    logic [AddrW-1:0]   o_found_address;
    logic [AddrW-1:0]   o_device_count;
    logic               o_scan_done;
    logic               o_none_found;

    // scanner model state
    t_cfg               scan_cfg  = '{7'd0, 8'd127, 16'd100, 16'd1000};
    t_phase             ph        = PH_IDLE;
    logic [AddrW-1:0]   probe_addr = '0;
    logic [BitIdxW-1:0] bit_pos   = '0;
    logic [AddrW-1:0]   ack_total = '0;
    logic [TicksW-1:0]  tick_wait = '0;
    logic               scl_drv   = 1'b1;
    logic               sda_drv   = 1'b1;
    logic               scan_over = 1'b0;

    t_result expected_ticks [$];
    int      mismatches = 0;
    int      beat_no    = 0;
    bit      tx_idle_on = 1'b0;
    bit      rx_idle_on = 1'b0;
    bit      backlog_req = 1'b0;
    bit      backlog_served = 1'b0;

    t_dir_row dir_table [DIR_ROWS] = '{
        '{1'b1, REG_SPARE_4,    16'hFFFF, 1'b0, 1'b0, 1'b1, BUS_IDLE},
        '{1'b1, REG_SPARE_5,    16'h0000, 1'b0, 1'b1, 1'b1, BUS_IDLE},
        '{1'b1, REG_SPARE_6,    16'hFFFF, 1'b0, 1'b0, 1'b1, BUS_IDLE},
        '{1'b1, REG_SPARE_7,    16'hFFFF, 1'b0, 1'b1, 1'b1, BUS_IDLE},
        '{1'b1, REG_SCAN_END,   16'h0000, 1'b1, 1'b1, 1'b1, DONE_EMPTY},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b0, 1'b1, DONE_EMPTY},
        '{1'b1, REG_SCAN_FIRST, 16'hFFFF, 1'b1, 1'b0, 1'b1, DONE_EMPTY},
        '{1'b1, REG_SCAN_END,   16'hFFFF, 1'b0, 1'b1, 1'b1, DONE_EMPTY},
        '{1'b1, REG_GAP_TICKS,  16'h0000, 1'b0, 1'b0, 1'b1, DONE_EMPTY},
        '{1'b1, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 1'b1, BUS_IDLE},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b1, 1'b0, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_SCAN_FIRST, 16'h0000, 1'b0, 1'b1, 1'b0, '0}
    };

    i2c_bus_address_scanner_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_go            (i_go),
        .i_sda_in        (i_sda_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_scl_out       (o_scl_out),
        .o_sda_out       (o_sda_out),
        .o_found_valid   (o_found_valid),
        .o_found_address (o_found_address),
        .o_device_count  (o_device_count),
        .o_scan_done     (o_scan_done),
        .o_none_found    (o_none_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // one bus tick of the scanner, returns the result beat it yields
    function automatic t_result advance_bus_tick(input logic go, input logic sda_seen);
        t_result         r;
        logic [EndW-1:0] end_lim;
        logic [7:0]      addr_byte;
        r = '0;
        end_lim = (scan_cfg.scan_end > END_LIMIT) ? END_LIMIT : scan_cfg.scan_end;
        addr_byte = {probe_addr, 1'b0};
        case (ph)
            PH_IDLE, PH_DONE: begin
                scl_drv = 1'b1;
                sda_drv = 1'b1;
                if (go) begin
                    ack_total = '0;
                    scan_over = 1'b0;
                    probe_addr = scan_cfg.scan_first;
                    if ({1'b0, probe_addr} >= end_lim) begin
                        scan_over = 1'b1;
                        ph = PH_DONE;
                    end else begin
                        ph = PH_START_A;
                    end
                end
            end
            PH_START_A: begin
                scl_drv = 1'b1;
                sda_drv = 1'b1;
                ph = PH_START_B;
            end
            PH_START_B: begin
                sda_drv = 1'b0;
                bit_pos = '0;
                ph = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
                scl_drv = 1'b0;
                ph = PH_BIT_SET;
            end
            PH_BIT_SET: begin
                sda_drv = addr_byte[LAST_BIT - bit_pos];
                ph = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
                scl_drv = 1'b1;
                if (bit_pos == LAST_BIT) begin
                    bit_pos = '0;
                    ph = PH_ACK_LOW;
                end else begin
                    bit_pos = bit_pos + 3'd1;
                    ph = PH_BIT_LOW;
                end
            end
            PH_ACK_LOW: begin
                scl_drv = 1'b0;
                ph = PH_ACK_REL;
            end
            PH_ACK_REL: begin
                sda_drv = 1'b1;
                ph = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                scl_drv = 1'b1;
                ph = PH_ACK_SAMP;
            end
            PH_ACK_SAMP: begin
                scl_drv = 1'b0;
                if (!sda_seen) begin
                    r.found_valid = 1'b1;
                    r.found_address = probe_addr;
                    if (ack_total < ADDR_MAX) ack_total = ack_total + 7'd1;
                    tick_wait = scan_cfg.found_hold_ticks;
                    ph = PH_HOLD;
                end else begin
                    ph = PH_STOP_A;
                end
            end
            PH_HOLD: begin
                if (tick_wait != '0) tick_wait = tick_wait - 16'd1;
                else ph = PH_STOP_A;
            end
            PH_STOP_A: begin
                scl_drv = 1'b0;
                ph = PH_STOP_B;
            end
            PH_STOP_B: begin
                sda_drv = 1'b0;
                ph = PH_STOP_C;
            end
            PH_STOP_C: begin
                scl_drv = 1'b1;
                ph = PH_STOP_D;
            end
            PH_STOP_D: begin
                sda_drv = 1'b1;
                tick_wait = scan_cfg.gap_ticks;
                ph = PH_GAP;
            end
            PH_GAP: begin
                if (tick_wait != '0) begin
                    tick_wait = tick_wait - 16'd1;
                end else if (probe_addr == ADDR_MAX ||
                             ({1'b0, probe_addr} + 8'd1) >= end_lim) begin
                    scan_over = 1'b1;
                    ph = PH_DONE;
                end else begin
                    probe_addr = probe_addr + 7'd1;
                    ph = PH_START_A;
                end
            end
            default: begin
                ph = PH_IDLE;
                scl_drv = 1'b1;
                sda_drv = 1'b1;
            end
        endcase
        r.scl_out = scl_drv;
        r.sda_out = sda_drv;
        r.device_count = ack_total;
        r.scan_done = scan_over;
        r.none_found = scan_over && (ack_total == '0);
        return r;
    endfunction

    // called at a rising edge; returns at the edge that takes the beat
    task automatic offer_tick(input logic go, input logic sda_seen, input logic use_typed,
                              input t_result typed_want);
        int      gap;
        t_result predicted;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 4);
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_go <= go;
        i_sda_in <= sda_seen;
        do @(negedge i_clk); while (o_in_stall !== 1'b0);
        @(posedge i_clk);
        predicted = advance_bus_tick(go, sda_seen);
        expected_ticks.push_back(use_typed ? typed_want : predicted);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TicksW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_SCAN_FIRST: scan_cfg.scan_first = data[AddrW-1:0];
            REG_SCAN_END:   scan_cfg.scan_end = data[EndW-1:0];
            REG_GAP_TICKS:  scan_cfg.gap_ticks = data;
            REG_HOLD_TICKS: scan_cfg.found_hold_ticks = data;
            default: ;
        endcase
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin : rx_side
        forever begin
            @(posedge i_clk);
            if (backlog_req && !backlog_served) begin
                i_out_stall <= 1'b1;
                repeat (BACKLOG_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                backlog_served = 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got = '{o_scl_out, o_sda_out, o_found_valid, o_found_address,
                    o_device_count, o_scan_done, o_none_found};
            beat_no++;
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: result beat with nothing expected", beat_no);
            end else begin
                want = expected_ticks.pop_front();
                if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                    got.found_valid !== want.found_valid ||
                    got.found_address !== want.found_address ||
                    got.device_count !== want.device_count ||
                    got.scan_done !== want.scan_done || got.none_found !== want.none_found)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: exp scl=%b sda=%b fv=%b addr=%0d",
                                 beat_no, want.scl_out, want.sda_out, want.found_valid,
                                 want.found_address, " cnt=%0d done=%b none=%b",
                                 want.device_count, want.scan_done, want.none_found,
                                 "\n          got scl=%b sda=%b fv=%b addr=%0d",
                                 got.scl_out, got.sda_out, got.found_valid, got.found_address,
                                 " cnt=%0d done=%b none=%b", got.device_count, got.scan_done,
                                 got.none_found);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("i2c_bus_address_scanner_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic [TicksW-1:0]  pick;
        logic [TicksW-1:0]  noise;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (dir_table[r]) begin
            if (dir_table[r].wr) begin
                wait_results_drained();
                write_reg(dir_table[r].idx, dir_table[r].data);
            end
            offer_tick(dir_table[r].go, dir_table[r].sda, dir_table[r].typed,
                       dir_table[r].want);
        end

        // small ranges and short delays so scans complete often
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_results_drained();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (p == BACKLOG_PHASE) begin
                tx_idle_on = 1'b0;
                backlog_req = 1'b1;
            end
            if (p == 0 || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0:       pick = '0;
                    1:       pick = TicksW'(ADDR_MAX);
                    default: pick = TicksW'($urandom_range(0, 127));
                endcase
                noise = TicksW'($urandom);
                write_reg(REG_SCAN_FIRST, {noise[15:7], pick[6:0]});
            end
            if (p == 0 || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 7))
                    0:       pick = '0;
                    1:       pick = TicksW'(END_LIMIT);
                    2:       pick = TicksW'($urandom_range(129, 255));
                    3:       pick = TicksW'($urandom_range(0, 255));
                    default: pick = TicksW'(scan_cfg.scan_first + $urandom_range(0, 4));
                endcase
                noise = TicksW'($urandom);
                write_reg(REG_SCAN_END, {noise[15:8], pick[7:0]});
            end
            if (p == 0 || $urandom_range(0, 1) == 1)
                write_reg(REG_GAP_TICKS, TicksW'(($urandom_range(0, 5) == 0) ?
                          $urandom_range(10, 60) : $urandom_range(0, 3)));
            if (p == 0 || $urandom_range(0, 1) == 1)
                write_reg(REG_HOLD_TICKS, TicksW'(($urandom_range(0, 5) == 0) ?
                          $urandom_range(10, 60) : $urandom_range(0, 6)));
            if ($urandom_range(0, 3) == 0) begin
                noise = TicksW'($urandom);
                write_reg(CfgIdxW'($urandom_range(REG_SPARE_4, REG_SPARE_7)), noise);
            end
            repeat ($urandom_range(90, 130))
                offer_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 1'b0, '0);
        end

        // largest delays loaded into the wait counter
        wait_results_drained();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_reg(REG_SCAN_FIRST, 16'hFF80);
        write_reg(REG_SCAN_END, 16'hFF80);
        write_reg(REG_GAP_TICKS, 16'hFFFF);
        write_reg(REG_HOLD_TICKS, 16'hFFFF);
        repeat (200)
            offer_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);

        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("i2c_bus_address_scanner_unit: match");
        else
            $display("i2c_bus_address_scanner_unit: mismatch");
        $finish;
    end

endmodule
